>>> hdl/sphere_pair_contact_resolve_defines.svh
// assertion macros used by the contact resolve checker
// depends on nothing; take it in with an include of the bare file name
`ifndef SPHERE_PAIR_CONTACT_RESOLVE_DEFINES_SVH
`define SPHERE_PAIR_CONTACT_RESOLVE_DEFINES_SVH

// same-cycle implication, off during reset
`define SPCR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spcr check failed");

// next-cycle implication, off during reset
`define SPCR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spcr check failed");

// what must hold in the cycle after reset is seen
`define SPCR_ASSERT_RESET(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("spcr check failed");

`endif

>>> hdl/spcr_pkg.sv
// types and constants for the circle pair contact resolver
// no dependencies
`timescale 1ns / 1ps

package spcr_pkg;

  localparam int POS_W  = 32;
  localparam int RAD_W  = 31;
  localparam int MASS_W = 24;
  localparam int OUTC_W = 2;
  localparam int DIST_W = 32;
  localparam int SUM_W  = MASS_W + 1;
  localparam int CX_W   = 33;
  localparam int unsigned EPS_DENOM = 1000000;

  typedef enum logic [OUTC_W-1:0] {
    OUTC_NONE     = 2'd0,
    OUTC_RESOLVED = 2'd1,
    OUTC_FIXED    = 2'd2
  } outcome_t;

  typedef struct packed {
    logic signed [POS_W-1:0] ax;
    logic signed [POS_W-1:0] ay;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] by;
    logic [MASS_W-1:0]       ia;
    logic [MASS_W-1:0]       ib;
    logic [SUM_W-1:0]        total;
    logic [DIST_W:0]         adx;
    logic [DIST_W:0]         ady;
    logic [DIST_W-1:0]       md;
    logic                    negx;
    logic                    negy;
    logic                    lt;
    logic                    ovl;
  } ctx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_a_x;
    logic signed [POS_W-1:0] new_a_y;
    logic signed [POS_W-1:0] new_b_x;
    logic signed [POS_W-1:0] new_b_y;
    outcome_t                outcome;
  } res_t;

endpackage

>>> hdl/spcr_pair_if.sv
// request and result channels of the contact resolver
// depends on spcr_pkg
`timescale 1ns / 1ps

interface spcr_pair_if import spcr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] a_pos_x;
  logic signed [POS_W-1:0] a_pos_y;
  logic signed [POS_W-1:0] b_pos_x;
  logic signed [POS_W-1:0] b_pos_y;
  logic [RAD_W-1:0]        a_radius;
  logic [RAD_W-1:0]        b_radius;
  logic [MASS_W-1:0]       a_inv_mass;
  logic [MASS_W-1:0]       b_inv_mass;

  modport source (output valid, a_pos_x, a_pos_y, b_pos_x, b_pos_y, a_radius, b_radius,
                  a_inv_mass, b_inv_mass, input ready);
  modport sink (input valid, a_pos_x, a_pos_y, b_pos_x, b_pos_y, a_radius, b_radius,
                a_inv_mass, b_inv_mass, output ready);
endinterface

interface spcr_result_if import spcr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] new_a_x;
  logic signed [POS_W-1:0] new_a_y;
  logic signed [POS_W-1:0] new_b_x;
  logic signed [POS_W-1:0] new_b_y;
  logic [OUTC_W-1:0]       outcome;

  modport source (output valid, new_a_x, new_a_y, new_b_x, new_b_y, outcome, input ready);
  modport sink (input valid, new_a_x, new_a_y, new_b_x, new_b_y, outcome, output ready);
endinterface

>>> hdl/spcr_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
// no dependencies; numerator must satisfy num >> QW < den
`timescale 1ns / 1ps

module spcr_div_pipe #(
  parameter int DW = 32,
  parameter int QW = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);

  logic [DW-1:0] rem [0:QW];
  logic [QW-1:0] wq  [0:QW];
  logic [DW-1:0] dv  [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num[DW+QW-1:QW];
      wq[0]  <= num[QW-1:0];
      dv[0]  <= den;
    end
  end

  // numerator bits shift out of wq while quotient bits shift in
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    assign t    = {rem[k], wq[k][QW-1]};
    assign ge   = t >= {1'b0, dv[k]};
    assign diff = t - {1'b0, dv[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
        wq[k+1]  <= {wq[k][QW-2:0], ge};
        dv[k+1]  <= dv[k];
      end
    end
  end

  assign quo = wq[QW];

endmodule

>>> hdl/sphere_pair_contact_resolve.sv
// contact resolve for one pair of 2D circles, fixed point, fully pipelined
// depends on spcr_pkg, spcr_pair_if, spcr_result_if and spcr_div_pipe
//
// pair carries one candidate circle pair per request: both centers, radii and
// inverse masses. resolved returns one result per request: the corrected
// centers (saturated) and an outcome code (no overlap, resolved, both fixed).
// a request is taken on any edge where pair.valid and pair.ready are high.
// throughput: one request per cycle while pair.ready is high. the bulk of the
// pipeline is the 32-stage square root and the two divider banks (center shift,
// then mass split).
// results come back in request order.
// reset (rst, synchronous) empties the pipeline and the output registers.
// when the receiver stalls, the held result stays on resolved and the next one
// lands in a skid register; in the cycle after, the pipeline freezes and
// pair.ready drops, and both come back as soon as the skid register drains.
`timescale 1ns / 1ps

module sphere_pair_contact_resolve import spcr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  spcr_pair_if.sink     pair,
  spcr_result_if.source resolved
);

  localparam int SQ_STEPS  = DIST_W;
  localparam int DIV_STEPS = CX_W;
  localparam int CA_W      = CX_W + MASS_W;
  localparam int unsigned EPS_LIM = ((1 << FRAC_BITS) + EPS_DENOM - 1) / EPS_DENOM;
  localparam logic [DIST_W-1:0] ONE     = DIST_W'(1) << FRAC_BITS;
  localparam logic [DIST_W-1:0] EPS_LIM_V = DIST_W'(EPS_LIM);

  function automatic logic signed [POS_W-1:0] apply_shift(
    input logic signed [POS_W-1:0] p,
    input logic [CX_W-1:0]         s,
    input logic                    add
  );
    logic signed [POS_W+2:0] w;
    logic signed [POS_W+2:0] smag;
    smag = $signed({2'b00, s});
    w    = add ? (35'(p) + smag) : (35'(p) - smag);
    if (w > 35'sd2147483647) begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end else if (w < -35'sd2147483648) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end
    return w[POS_W-1:0];
  endfunction

  logic en;
  logic skid_valid;
  logic out_valid;

  assign en         = !skid_valid;
  assign pair.ready = en;

  // valid bits
  logic                v0, v1, v2, vE, vM, vC, vF;
  logic [SQ_STEPS:0]   sq_v;
  logic [DIV_STEPS:0]  d1_v;
  logic [DIV_STEPS:0]  d2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      vE   <= 1'b0;
      vM   <= 1'b0;
      vC   <= 1'b0;
      vF   <= 1'b0;
      sq_v <= '0;
      d1_v <= '0;
      d2_v <= '0;
    end else if (en) begin
      v0   <= pair.valid;
      v1   <= v0;
      v2   <= v1;
      sq_v <= {sq_v[SQ_STEPS-1:0], v2};
      vE   <= sq_v[SQ_STEPS];
      vM   <= vE;
      d1_v <= {d1_v[DIV_STEPS-1:0], vM};
      vC   <= d1_v[DIV_STEPS];
      d2_v <= {d2_v[DIV_STEPS-1:0], vC};
      vF   <= d2_v[DIV_STEPS];
    end
  end

  // stage 0: capture
  ctx_t             c0, c0_next;
  logic [RAD_W-1:0] ra0, rb0;

  always_comb begin
    c0_next    = '0;
    c0_next.ax = pair.a_pos_x;
    c0_next.ay = pair.a_pos_y;
    c0_next.bx = pair.b_pos_x;
    c0_next.by = pair.b_pos_y;
    c0_next.ia = pair.a_inv_mass;
    c0_next.ib = pair.b_inv_mass;
  end

  // stage 1: deltas, magnitudes, contact distance
  ctx_t                 c1, c1_next;
  logic signed [POS_W:0] dx1, dy1;

  always_comb begin
    c1_next      = c0;
    dx1          = 33'(c0.bx) - 33'(c0.ax);
    dy1          = 33'(c0.by) - 33'(c0.ay);
    c1_next.negx = dx1[POS_W];
    c1_next.negy = dy1[POS_W];
    c1_next.adx  = dx1[POS_W] ? (-dx1) : dx1;
    c1_next.ady  = dy1[POS_W] ? (-dy1) : dy1;
    c1_next.md   = DIST_W'(ra0) + DIST_W'(rb0);
  end

  // stage 2: squares
  ctx_t                  c2, c2_next;
  logic [2*DIST_W-1:0]   dx2, dy2, md2;

  always_comb begin
    c2_next    = c1;
    c2_next.lt = (c1.adx < {1'b0, c1.md}) && (c1.ady < {1'b0, c1.md});
  end

  // stage 3: squared distance and overlap test, feeds the root
  logic [2*DIST_W:0]   d2;
  ctx_t                cs_next;
  logic [2*DIST_W-1:0] sq_n    [0:SQ_STEPS];
  logic [DIST_W+1:0]   sq_rem  [0:SQ_STEPS];
  logic [DIST_W-1:0]   sq_root [0:SQ_STEPS];
  ctx_t                sq_c    [0:SQ_STEPS];

  always_comb begin
    d2          = {1'b0, dx2} + {1'b0, dy2};
    cs_next     = c2;
    cs_next.ovl = c2.lt && (d2 < {1'b0, md2});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0         <= c0_next;
      ra0        <= pair.a_radius;
      rb0        <= pair.b_radius;
      c1         <= c1_next;
      c2         <= c2_next;
      dx2        <= c1.adx[DIST_W-1:0] * c1.adx[DIST_W-1:0];
      dy2        <= c1.ady[DIST_W-1:0] * c1.ady[DIST_W-1:0];
      md2        <= c1.md * c1.md;
      sq_n[0]    <= d2[2*DIST_W-1:0];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_c[0]    <= cs_next;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [DIST_W+3:0] t;
    logic [DIST_W+3:0] trial;
    logic [DIST_W+3:0] diff;
    logic              ge;
    assign t     = {sq_rem[k], sq_n[k][2*DIST_W-1:2*DIST_W-2]};
    assign trial = {2'b00, sq_root[k], 2'b01};
    assign ge    = t >= trial;
    assign diff  = t - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k+1]  <= ge ? diff[DIST_W+1:0] : t[DIST_W+1:0];
        sq_root[k+1] <= {sq_root[k][DIST_W-2:0], ge};
        sq_n[k+1]    <= {sq_n[k][2*DIST_W-3:0], 2'b00};
        sq_c[k+1]    <= sq_c[k];
      end
    end
  end

  // stage E: coincident centers fallback, penetration depth
  ctx_t                    cE, cE_next;
  logic [DIST_W-1:0]       root_e, dist_e, distE;
  logic                    coin, penneg;
  logic signed [DIST_W+1:0] pen, apen_full;
  logic [DIST_W-1:0]       apen_next, apenE;

  always_comb begin
    cE_next   = sq_c[SQ_STEPS];
    root_e    = sq_root[SQ_STEPS];
    coin      = root_e < EPS_LIM_V;
    dist_e    = coin ? ONE : root_e;
    pen       = $signed({2'b00, cE_next.md}) - $signed({2'b00, dist_e});
    penneg    = pen[DIST_W+1];
    apen_full = penneg ? (-pen) : pen;
    apen_next = apen_full[DIST_W-1:0];
    cE_next.adx   = coin ? {1'b0, ONE} : sq_c[SQ_STEPS].adx;
    cE_next.ady   = coin ? '0 : sq_c[SQ_STEPS].ady;
    cE_next.negx  = (coin ? 1'b0 : sq_c[SQ_STEPS].negx) ^ penneg;
    cE_next.negy  = (coin ? 1'b0 : sq_c[SQ_STEPS].negy) ^ penneg;
    cE_next.total = SUM_W'(sq_c[SQ_STEPS].ia) + SUM_W'(sq_c[SQ_STEPS].ib);
  end

  // stage M: offset times depth
  ctx_t                cM;
  logic [2*DIST_W-1:0] pxM, pyM;
  logic [DIST_W-1:0]   distM;

  always_ff @(posedge clk) begin
    if (en) begin
      cE    <= cE_next;
      distE <= dist_e;
      apenE <= apen_next;
      cM    <= cE;
      pxM   <= cE.adx[DIST_W-1:0] * apenE;
      pyM   <= cE.ady[DIST_W-1:0] * apenE;
      distM <= distE;
    end
  end

  // per-axis correction, rounded: (p + dist/2) / dist
  logic [DIST_W+CX_W-1:0] num_cx, num_cy;
  logic [CX_W-1:0]        cx, cy;

  assign num_cx = {1'b0, pxM} + (DIST_W + CX_W)'(distM >> 1);
  assign num_cy = {1'b0, pyM} + (DIST_W + CX_W)'(distM >> 1);

  spcr_div_pipe #(.DW(DIST_W), .QW(CX_W)) u_div_cx (
    .clk (clk), .en (en), .num (num_cx), .den (distM), .quo (cx)
  );
  spcr_div_pipe #(.DW(DIST_W), .QW(CX_W)) u_div_cy (
    .clk (clk), .en (en), .num (num_cy), .den (distM), .quo (cy)
  );

  ctx_t d1_c [0:DIV_STEPS];

  // stage C: split by inverse mass
  ctx_t            cC;
  logic [CA_W-1:0] caxC, cayC, cbxC, cbyC;

  always_ff @(posedge clk) begin
    if (en) begin
      d1_c[0] <= cM;
      for (int i = DIV_STEPS; i > 0; i--) begin
        d1_c[i] <= d1_c[i-1];
      end
      cC   <= d1_c[DIV_STEPS];
      caxC <= cx * d1_c[DIV_STEPS].ia;
      cayC <= cy * d1_c[DIV_STEPS].ia;
      cbxC <= cx * d1_c[DIV_STEPS].ib;
      cbyC <= cy * d1_c[DIV_STEPS].ib;
    end
  end

  logic [SUM_W+CX_W-1:0] num_ax, num_ay, num_bx, num_by;
  logic [SUM_W+CX_W-1:0] half_tot;
  logic [CX_W-1:0]       sax, say, sbx, sby;

  assign half_tot = (SUM_W + CX_W)'(cC.total >> 1);
  assign num_ax   = {1'b0, caxC} + half_tot;
  assign num_ay   = {1'b0, cayC} + half_tot;
  assign num_bx   = {1'b0, cbxC} + half_tot;
  assign num_by   = {1'b0, cbyC} + half_tot;

  spcr_div_pipe #(.DW(SUM_W), .QW(CX_W)) u_div_ax (
    .clk (clk), .en (en), .num (num_ax), .den (cC.total), .quo (sax)
  );
  spcr_div_pipe #(.DW(SUM_W), .QW(CX_W)) u_div_ay (
    .clk (clk), .en (en), .num (num_ay), .den (cC.total), .quo (say)
  );
  spcr_div_pipe #(.DW(SUM_W), .QW(CX_W)) u_div_bx (
    .clk (clk), .en (en), .num (num_bx), .den (cC.total), .quo (sbx)
  );
  spcr_div_pipe #(.DW(SUM_W), .QW(CX_W)) u_div_by (
    .clk (clk), .en (en), .num (num_by), .den (cC.total), .quo (sby)
  );

  ctx_t d2_c [0:DIV_STEPS];

  // stage F: apply shifts, saturate, pick outcome
  ctx_t cF;
  res_t resF, resF_next, resO, resS;

  always_comb begin
    cF        = d2_c[DIV_STEPS];
    resF_next.new_a_x = cF.ax;
    resF_next.new_a_y = cF.ay;
    resF_next.new_b_x = cF.bx;
    resF_next.new_b_y = cF.by;
    resF_next.outcome = OUTC_NONE;
    if (cF.ovl) begin
      if (cF.total == '0) begin
        resF_next.outcome = OUTC_FIXED;
      end else begin
        // a moves against the normal, b along it
        resF_next.new_a_x = apply_shift(cF.ax, sax, cF.negx);
        resF_next.new_a_y = apply_shift(cF.ay, say, cF.negy);
        resF_next.new_b_x = apply_shift(cF.bx, sbx, !cF.negx);
        resF_next.new_b_y = apply_shift(cF.by, sby, !cF.negy);
        resF_next.outcome = OUTC_RESOLVED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_c[0] <= cC;
      for (int i = DIV_STEPS; i > 0; i--) begin
        d2_c[i] <= d2_c[i-1];
      end
      resF <= resF_next;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || resolved.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= vF;
      end
    end else if (vF && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || resolved.ready) begin
      resO <= skid_valid ? resS : resF;
    end
    if (en && out_valid && !resolved.ready) begin
      resS <= resF;
    end
  end

  assign resolved.valid   = out_valid;
  assign resolved.new_a_x = resO.new_a_x;
  assign resolved.new_a_y = resO.new_a_y;
  assign resolved.new_b_x = resO.new_b_x;
  assign resolved.new_b_y = resO.new_b_y;
  assign resolved.outcome = resO.outcome;

endmodule

>>> hdl/spcr_checker.sv
// port-level checks for the contact resolver, bound to the top level
// depends on spcr_pkg and sphere_pair_contact_resolve_defines.svh
`timescale 1ns / 1ps
`include "sphere_pair_contact_resolve_defines.svh"

module spcr_checker import spcr_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    pair_ready,
  input logic                    res_valid,
  input logic                    res_ready,
  input logic signed [POS_W-1:0] new_a_x,
  input logic signed [POS_W-1:0] new_a_y,
  input logic signed [POS_W-1:0] new_b_x,
  input logic signed [POS_W-1:0] new_b_y,
  input logic [OUTC_W-1:0]       outcome
);

  // a stalled result stays put
  `SPCR_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(new_a_x) && $stable(new_a_y) && $stable(new_b_x) && $stable(new_b_y) && $stable(outcome))

  // reset leaves the block empty and ready
  `SPCR_ASSERT_RESET(a_rdy_rst, clk, rst, pair_ready && !res_valid)

  // request side backs off only behind a held result
  `SPCR_ASSERT_NOW(a_rdy_low, clk, rst, !pair_ready, res_valid)

  // ready drops only in the cycle after the receiver stalled
  `SPCR_ASSERT_NOW(a_rdy_fall, clk, rst, $fell(pair_ready), $past(res_valid && !res_ready))

endmodule

bind sphere_pair_contact_resolve spcr_checker u_spcr_checker (
  .clk        (clk),
  .rst        (rst),
  .pair_ready (pair.ready),
  .res_valid  (resolved.valid),
  .res_ready  (resolved.ready),
  .new_a_x    (resolved.new_a_x),
  .new_a_y    (resolved.new_a_y),
  .new_b_x    (resolved.new_b_x),
  .new_b_y    (resolved.new_b_y),
  .outcome    (resolved.outcome)
);
